/* design/msbp_pkg.sv */
`timescale 1ns / 1ps
package msbp_pkg;

  localparam int CAPACITY_BYTES_DEF = 8192;
  localparam int MAX_FIELD_BITS_DEF = 32;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_APPEND_REJECT = 2'd1,
    ST_READ_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] write_value;
    logic [5:0]  field_width;
    logic [15:0] bit_position;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [16:0] fill_bits;
    status_t     status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_WAIT,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic wr_step;
    logic rd_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_err;
    logic in_read;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* design/msb_first_bit_packer.sv */
`timescale 1ns / 1ps
// channel | ports                                  | payload
// in      | in_valid, in_ready, in_data            | cmd, write_value, field_width, bit_position
// out     | out_valid, out_ready, out_data         | read_value, fill_bits, status
//
// One item at a time. A field touching n bytes (1..5) is loaded, written one byte per step
// through the single byte-wide store port, then finished; a read reads its bytes, waits for
// the last registered read data, then finishes; a rejected item goes from load to finish.
// Reset (rst_n low, synchronous) clears the bit count; store contents are not cleared.
// A new beat is accepted while the previous result still waits in the output register;
// a stalled out_ready holds the finished result until taken.
module msb_first_bit_packer #(
  parameter int CAPACITY_BYTES = msbp_pkg::CAPACITY_BYTES_DEF,
  parameter int MAX_FIELD_BITS = msbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  msbp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output msbp_pkg::out_t  out_data
);
  import msbp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  msbp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  msbp_datapath #(
    .CAPACITY_BYTES(CAPACITY_BYTES),
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* design/msbp_ram.sv */
`timescale 1ns / 1ps
module msbp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/msbp_ctrl.sv */
`timescale 1ns / 1ps
module msbp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msbp_pkg::dp_stat_t   stat,
  output msbp_pkg::ctrl_cmd_t  cmd
);
  import msbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_err) begin
            state_nxt = S_FINISH;
          end else if (stat.in_read) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (stat.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        if (stat.last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
      end
      S_READ: begin
        cmd.rd_step = 1'b1;
      end
      S_WAIT: begin
      end
      S_FINISH: begin
        cmd.finish = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

  // a write sequence only starts from an accepted beat
  a_write_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> ($past(state_r) == S_IDLE || $past(state_r) == S_WRITE))
    else $error("write sequence entered without load");

  a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> ($past(state_r) == S_READ))
    else $error("wait state not preceded by read");

endmodule

/* design/msbp_datapath.sv */
`timescale 1ns / 1ps
module msbp_datapath #(
  parameter int CAPACITY_BYTES = msbp_pkg::CAPACITY_BYTES_DEF,
  parameter int MAX_FIELD_BITS = msbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msbp_pkg::in_t        in_data,
  input  msbp_pkg::ctrl_cmd_t  cmd,
  output msbp_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msbp_pkg::out_t       out_data
);
  import msbp_pkg::*;

  localparam int CAP_BITS = CAPACITY_BYTES * 8;
  localparam int CNT_RAW  = $clog2(CAP_BITS + 1);
  localparam int CNT_W    = (CNT_RAW > 17) ? CNT_RAW : 17;
  localparam int ADDR_W   = (CAPACITY_BYTES > 1) ? $clog2(CAPACITY_BYTES) : 1;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [5:0]        w_r;
  logic [5:0]        sh_r;
  logic [2:0]        n_r;
  logic [2:0]        k_r;
  logic [ADDR_W-1:0] addr_r;
  logic [39:0]       sr_r;
  logic [7:0]        tail_r;
  logic [39:0]       acc_r;
  logic              rd_valid_r;
  logic [2:0]        slot_r;
  logic              err_r;
  logic              read_r;
  status_t           status_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [5:0]        w;
  logic              width_ok;
  logic [CNT_W:0]    app_sum, rd_sum;
  logic              app_err, rd_err, in_err, in_read;
  logic [2:0]        o;
  logic [6:0]        span;
  logic [5:0]        sh;
  logic [2:0]        n;
  logic [31:0]       val_m;
  logic [7:0]        tail_m;
  logic [39:0]       sr_load;
  logic [31:0]       wa, ra;
  logic [7:0]        rdata;
  logic [31:0]       mask, ext, result;

  assign w        = in_data.field_width;
  assign width_ok = (w != 6'd0) && ({1'b0, w} <= 7'(MAX_FIELD_BITS));
  assign app_sum  = (CNT_W+1)'(count_r) + (CNT_W+1)'(w);
  assign rd_sum   = (CNT_W+1)'(in_data.bit_position) + (CNT_W+1)'(w);
  assign app_err  = !width_ok || (app_sum > (CNT_W+1)'(CAP_BITS));
  assign rd_err   = !width_ok || (rd_sum > (CNT_W+1)'(count_r));
  assign in_read  = (in_data.cmd == CMD_READ);
  assign in_err   = in_read ? rd_err : app_err;

  // bit offset in the first byte touched, and how many bytes the field spans
  assign o    = in_read ? in_data.bit_position[2:0] : count_r[2:0];
  assign span = 7'(o) + 7'(w);
  assign sh   = 6'(7'd40 - span);
  assign n    = 3'((span + 7'd7) >> 3);

  assign val_m   = in_data.write_value & (32'hFFFF_FFFF >> (6'd32 - w));
  assign tail_m  = tail_r & ~(8'hFF >> count_r[2:0]);
  assign sr_load = {tail_m, 32'h0} | ({8'h0, val_m} << sh);

  assign wa = 32'(count_r) >> 3;
  assign ra = 32'(in_data.bit_position) >> 3;

  always_comb begin
    count_nxt = count_r;
    if (cmd.load && !in_read && !app_err) begin
      count_nxt = count_r + CNT_W'(w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      rd_valid_r <= cmd.rd_step;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r      <= w;
      sh_r     <= sh;
      n_r      <= n;
      k_r      <= 3'd0;
      addr_r   <= in_read ? ra[ADDR_W-1:0] : wa[ADDR_W-1:0];
      sr_r     <= sr_load;
      acc_r    <= '0;
      err_r    <= in_err;
      read_r   <= in_read;
      status_r <= !in_err ? ST_OK : (in_read ? ST_READ_RANGE : ST_APPEND_REJECT);
    end else begin
      if (cmd.wr_step || cmd.rd_step) begin
        k_r    <= k_r + 3'd1;
        addr_r <= addr_r + ADDR_W'(1);
      end
      if (cmd.wr_step) begin
        sr_r   <= {sr_r[31:0], 8'h0};
        tail_r <= sr_r[39:32];
      end
      if (rd_valid_r) begin
        acc_r <= acc_r | ({rdata, 32'h0} >> {slot_r, 3'b000});
      end
    end
    if (cmd.rd_step) begin
      slot_r <= k_r;
    end
    if (cmd.finish) begin
      out_data_r.read_value <= result;
      out_data_r.fill_bits  <= count_r[16:0];
      out_data_r.status     <= status_r;
    end
  end

  msbp_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY_BYTES),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_step),
    .addr (addr_r),
    .wdata(sr_r[39:32]),
    .rdata(rdata)
  );

  assign mask   = 32'hFFFF_FFFF >> (6'd32 - w_r);
  assign ext    = 32'(acc_r >> sh_r) & mask;
  assign result = (err_r || !read_r) ? 32'h0 : ext;

  assign stat.in_err   = in_err;
  assign stat.in_read  = in_read;
  assign stat.last     = (k_r == n_r - 3'd1);
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAP_BITS))
    else $error("bit count passed capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a pending beat");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_step || cmd.rd_step) |-> (k_r < 3'd5))
    else $error("byte step count out of range");

  a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> !cmd.wr_step)
    else $error("write issued while read data pending");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import msbp_pkg::*;

  localparam int CAP_BITS     = CAPACITY_BYTES_DEF * 8;
  localparam int MAX_W        = MAX_FIELD_BITS_DEF;
  localparam int RANDOM_ITEMS = 560;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_SPACING = 1400;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_q[$];
  out_t expected_results[$];

  // shadow of the bit store, updated as beats are accepted
  logic [7:0]  shadow_bytes [0:CAPACITY_BYTES_DEF-1];
  int unsigned shadow_fill = 0;

  int gen_fill = 0;  // fill level seen by the stimulus generator
  int total_items = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int taken_cnt = 0;
  int next_hold_at = 150;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  msb_first_bit_packer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic out_t predict_beat(in_t b);
    out_t        r;
    int          w;
    int unsigned pos;
    int unsigned n;
    r.read_value = '0;
    r.status     = ST_OK;
    w            = int'(b.field_width);
    pos          = b.bit_position;
    if (b.cmd == CMD_APPEND) begin
      if (w < 1 || w > MAX_W || shadow_fill + w > CAP_BITS) begin
        r.status = ST_APPEND_REJECT;
      end else begin
        for (int k = w - 1; k >= 0; k--) begin
          // first bit of a byte starts it from zero
          if (shadow_fill % 8 == 0) shadow_bytes[shadow_fill / 8] = 8'h00;
          shadow_bytes[shadow_fill / 8][7 - shadow_fill % 8] = b.write_value[k];
          shadow_fill++;
        end
      end
    end else begin
      if (w < 1 || w > MAX_W || pos + w > shadow_fill) begin
        r.status = ST_READ_RANGE;
      end else begin
        for (int j = 0; j < w; j++) begin
          n = pos + j;
          r.read_value = {r.read_value[30:0], shadow_bytes[n / 8][7 - n % 8]};
        end
      end
    end
    r.fill_bits = shadow_fill[16:0];
    return r;
  endfunction

  function automatic void queue_beat(logic cmd, logic [31:0] val, int w, int pos);
    in_t b;
    b.cmd          = cmd;
    b.write_value  = val;
    b.field_width  = w[5:0];
    b.bit_position = pos[15:0];
    if (cmd == CMD_APPEND && w >= 1 && w <= MAX_W && gen_fill + w <= CAP_BITS)
      gen_fill += w;
    pending_q = {pending_q, b};
  endfunction

  // read wholly inside the filled region; caller ensures gen_fill > 0
  function automatic void queue_valid_read();
    int w;
    w = $urandom_range(1, gen_fill < 32 ? gen_fill : 32);
    queue_beat(CMD_READ, $urandom, w, $urandom_range(0, gen_fill - w));
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("MISMATCH: %s", msg);
  endtask

  initial begin
    int r;
    int w;

    // directed: width limits, excess value bits, reads at the fill edge
    queue_beat(CMD_READ, 32'h0, 1, 0);
    queue_beat(CMD_APPEND, 32'h1, 0, 0);
    queue_beat(CMD_APPEND, 32'hFFFF_FFFF, 33, 16'hFFFF);
    queue_beat(CMD_APPEND, 32'hFFFF_FFFF, 63, 0);
    queue_beat(CMD_APPEND, 32'h0000_0001, 1, 16'hFFFF);
    queue_beat(CMD_APPEND, 32'hFFFF_FFFF, 32, 0);
    queue_beat(CMD_APPEND, 32'h0000_0000, 32, 0);
    queue_beat(CMD_APPEND, 32'hDEAD_BE5A, 7, 0);
    queue_beat(CMD_APPEND, 32'h0000_00A5, 8, 0);
    queue_beat(CMD_APPEND, 32'h8000_0001, 32, 0);
    queue_beat(CMD_READ, 32'hFFFF_FFFF, 1, 0);
    queue_beat(CMD_READ, 32'h0, 32, 0);
    queue_beat(CMD_READ, 32'h0, 32, 1);
    queue_beat(CMD_READ, 32'h0, 32, gen_fill - 32);
    queue_beat(CMD_READ, 32'h0, 1, gen_fill - 1);
    queue_beat(CMD_READ, 32'h0, 1, gen_fill);
    queue_beat(CMD_READ, 32'h0, 32, gen_fill - 31);
    queue_beat(CMD_READ, 32'h0, 0, 0);
    queue_beat(CMD_READ, 32'h0, 40, 0);
    queue_beat(CMD_READ, 32'h0, 63, 0);
    queue_beat(CMD_READ, 32'h0, 32, 16'hFFFF);
    queue_beat(CMD_READ, 32'h0, 8, 72);

    // random mix
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        case ($urandom_range(0, 19))
          0:       w = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
          1, 2, 3: w = $urandom_range(1, 4);
          default: w = $urandom_range(1, 32);
        endcase
        queue_beat(CMD_APPEND, $urandom, w, $urandom_range(0, 65535));
      end else if (r < 90 && gen_fill > 0) begin
        queue_valid_read();
      end else if (r < 95) begin
        queue_beat(CMD_READ, $urandom, $urandom_range(0, 63), $urandom_range(0, 65535));
      end else begin
        w = $urandom_range(1, 32);
        queue_beat(CMD_READ, $urandom, w, gen_fill + 1 > w ? gen_fill + 1 - w : 0);
      end
    end

    // tail: valid reads and appends mixed
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 1) && gen_fill > 0)
        queue_valid_read();
      else
        queue_beat(CMD_APPEND, $urandom, $urandom_range(1, 32), $urandom);
    end
    total_items = pending_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_items || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_beat(in_data)};
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
          gap_left = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver; a long hold now and then lets the block back up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken_cnt++;
      if ($urandom_range(0, 255) == 0) out_calm = !out_calm;
      if (hold_left == 0 && taken_cnt >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(out_calm);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%h fill=%0d status=%0d",
                                  out_data.read_value, out_data.fill_bits,
                                  out_data.status));
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_value !== want.read_value)
          report_mismatch($sformatf("beat %0d read_value %h, want %h", checked_cnt,
                                    out_data.read_value, want.read_value));
        if (out_data.fill_bits !== want.fill_bits)
          report_mismatch($sformatf("beat %0d fill_bits %0d, want %0d", checked_cnt,
                                    out_data.fill_bits, want.fill_bits));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("beat %0d status %0d, want %0d", checked_cnt,
                                    out_data.status, want.status));
      end
      checked_cnt++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
